/* rtl/core/lbvs_pkg.sv */
// Shared constants and types for the vertex skinning block.
// No dependencies; lbvs_norm, the top level and the testbench import this package.
package lbvs_pkg;
   localparam int MAX_BONES   = 256;
   localparam int INFLUENCES  = 4;
   localparam int PACKED_INFL = 4;
   localparam int MAT_WORDS   = 12;
   localparam int MAT_COLS    = 4;
   localparam int WEIGHT_EPS  = 6;
   localparam int NRM_ONE     = 16384;
   localparam int STORE_DEPTH = MAX_BONES * MAT_WORDS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int BONE_W      = $clog2(MAX_BONES);
   localparam int KIDX_W      = $clog2(INFLUENCES + 1);
   localparam int ROW_W       = 50;
   localparam int ACC_W       = 52;
   localparam int REQ_W       = 320;
   localparam int RSP_W       = 144;
   localparam int BCNT_W      = 9;

   typedef enum logic {
      OP_SKIN = 1'b0,
      OP_LOAD = 1'b1
   } op_type;
endpackage

/* rtl/core/lbvs_ram.sv */
// Generic single-port-write, single-port-read synchronous RAM.
// Registered read data. No dependencies.
module lbvs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

/* rtl/core/lbvs_norm.sv */
// Iterative normal normaliser: shift to range, sum of squares, bit-pair
// square root, then three restoring divisions. Depends on lbvs_pkg.
module lbvs_norm (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [lbvs_pkg::ACC_W-1:0]  vec_x,
   input  logic signed [lbvs_pkg::ACC_W-1:0]  vec_y,
   input  logic signed [lbvs_pkg::ACC_W-1:0]  vec_z,
   output logic                               done,
   output logic signed [15:0]                 nrm_x,
   output logic signed [15:0]                 nrm_y,
   output logic signed [15:0]                 nrm_z
);
   import lbvs_pkg::*;

   typedef enum logic [6:0] {
      NS_IDLE  = 7'b0000001,
      NS_SCALE = 7'b0000010,
      NS_SQ    = 7'b0000100,
      NS_ROOT  = 7'b0001000,
      NS_DSET  = 7'b0010000,
      NS_DIV   = 7'b0100000,
      NS_DONE  = 7'b1000000
   } nstate_type;

   nstate_type         st_ff, st_in;
   logic [ACC_W-1:0]   a_ff [3];
   logic [ACC_W-1:0]   a_in [3];
   logic [2:0]         neg_ff, neg_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [1:0]         idx_ff, idx_in;
   logic [59:0]        sq_ff, sq_in;
   logic [61:0]        sum_ff, sum_in;
   logic [63:0]        v_ff, v_in;
   logic [63:0]        root_ff, root_in;
   logic [63:0]        bit_ff, bit_in;
   logic [30:0]        len_ff, len_in;
   logic [30:0]        rem_ff, rem_in;
   logic [14:0]        nb_ff, nb_in;
   logic [14:0]        q_ff, q_in;
   logic signed [15:0] o_ff [3];
   logic signed [15:0] o_in [3];

   logic [ACC_W-1:0]   mx;
   logic [ACC_W-1:0]   cin [3];
   logic [63:0]        trial;
   logic [44:0]        num;
   logic [31:0]        tdiv;
   logic [15:0]        qclamp;

   assign cin[0] = vec_x;
   assign cin[1] = vec_y;
   assign cin[2] = vec_z;

   always_comb begin
      mx = a_ff[0];
      if (a_ff[1] > mx) begin
         mx = a_ff[1];
      end
      if (a_ff[2] > mx) begin
         mx = a_ff[2];
      end
   end

   always_comb begin
      st_in   = st_ff;
      a_in    = a_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      sq_in   = sq_ff;
      sum_in  = sum_ff;
      v_in    = v_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      len_in  = len_ff;
      rem_in  = rem_ff;
      nb_in   = nb_ff;
      q_in    = q_ff;
      o_in    = o_ff;
      trial   = root_ff + bit_ff;
      num     = {a_ff[idx_ff][29:0], 14'b0} + 45'(len_ff >> 1);
      tdiv    = {rem_ff, nb_ff[14]};
      qclamp  = 16'(q_ff);
      case (st_ff)
         NS_IDLE: begin
            if (start) begin
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = cin[i][ACC_W-1];
                  a_in[i]   = cin[i][ACC_W-1] ? (~cin[i] + 1'b1) : cin[i];
               end
               st_in = NS_SCALE;
            end
         end
         NS_SCALE: begin
            if (mx == '0) begin
               for (int i = 0; i < 3; i++) begin
                  o_in[i] = '0;
               end
               st_in = NS_DONE;
            end else if (mx[ACC_W-1:30] != '0) begin
               for (int i = 0; i < 3; i++) begin
                  a_in[i] = a_ff[i] >> 1;
               end
            end else if (!mx[29]) begin
               for (int i = 0; i < 3; i++) begin
                  a_in[i] = a_ff[i] << 1;
               end
            end else begin
               cnt_in = '0;
               sum_in = '0;
               st_in  = NS_SQ;
            end
         end
         NS_SQ: begin
            // square one component a cycle, add the previous square
            if (cnt_ff != 4'd3) begin
               sq_in = a_ff[cnt_ff[1:0]][29:0] * a_ff[cnt_ff[1:0]][29:0];
            end
            if (cnt_ff != 4'd0) begin
               sum_in = sum_ff + 62'(sq_ff);
            end
            if (cnt_ff == 4'd3) begin
               v_in    = 64'(sum_ff + 62'(sq_ff));
               root_in = '0;
               bit_in  = 64'd1 << 62;
               st_in   = NS_ROOT;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         NS_ROOT: begin
            if (v_ff >= trial) begin
               v_in    = v_ff - trial;
               root_in = (root_ff >> 1) + bit_ff;
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               len_in = root_in[30:0];
               idx_in = '0;
               st_in  = NS_DSET;
            end
         end
         NS_DSET: begin
            rem_in = 31'(num[44:15]);
            nb_in  = num[14:0];
            q_in   = '0;
            cnt_in = '0;
            st_in  = NS_DIV;
         end
         NS_DIV: begin
            if (tdiv >= {1'b0, len_ff}) begin
               rem_in = 31'(tdiv - {1'b0, len_ff});
               q_in   = {q_ff[13:0], 1'b1};
            end else begin
               rem_in = tdiv[30:0];
               q_in   = {q_ff[13:0], 1'b0};
            end
            nb_in  = nb_ff << 1;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd14) begin
               qclamp = 16'(q_in);
               if (qclamp > 16'(NRM_ONE)) begin
                  qclamp = 16'(NRM_ONE);
               end
               o_in[idx_ff] = neg_ff[idx_ff] ? -$signed(qclamp) : $signed(qclamp);
               if (idx_ff == 2'd2) begin
                  st_in = NS_DONE;
               end else begin
                  idx_in = idx_ff + 2'd1;
                  st_in  = NS_DSET;
               end
            end
         end
         NS_DONE: begin
            st_in = NS_IDLE;
         end
         default: begin
            st_in = NS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= NS_IDLE;
      end else begin
         st_ff <= st_in;
      end
      a_ff    <= a_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      sq_ff   <= sq_in;
      sum_ff  <= sum_in;
      v_ff    <= v_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      len_ff  <= len_in;
      rem_ff  <= rem_in;
      nb_ff   <= nb_in;
      q_ff    <= q_in;
      o_ff    <= o_in;
   end

   assign done  = (st_ff == NS_DONE);
   assign nrm_x = o_ff[0];
   assign nrm_y = o_ff[1];
   assign nrm_z = o_ff[2];
endmodule

/* rtl/core/linear_blend_vertex_skinning.sv */
// Linear blend skinning, four influences, matrix store in one RAM.
// Load beat: no result. Skin beat: per active influence, 12 RAM reads (each
// through read, capture and accumulate states) plus weighting, then normalising
// (shift to range, squaring, 32 root steps, three divides). One vertex at a
// time; a finished result waits in the output register. Synchronous active-high
// reset clears control state and bone_count; the store is not cleared.
module linear_blend_vertex_skinning (
   input  logic                          clock,
   input  logic                          reset,
   // request: tdata = pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, influence_bones,
   //          influence_weights, load_bone, load_entry, load_value, 4 bits pad
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [lbvs_pkg::REQ_W-1:0]    req_tdata,
   input  logic [0:0]                    req_tuser,   // op
   // response: tdata = out_pos_x, out_pos_y, out_pos_z, out_nrm_x, out_nrm_y,
   //           out_nrm_z
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [lbvs_pkg::RSP_W-1:0]    rsp_tdata,
   output logic [0:0]                    rsp_tuser,   // passed_through
   // bone_count register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lbvs_pkg::BCNT_W-1:0]   csr_wdata
);
   import lbvs_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_INFL = 9'b000000010,
      S_RD   = 9'b000000100,
      S_EX   = 9'b000001000,
      S_AC   = 9'b000010000,
      S_WT   = 9'b000100000,
      S_WA   = 9'b001000000,
      S_NORM = 9'b010000000,
      S_OUT  = 9'b100000000
   } state_type;

   // request fields
   logic signed [31:0] req_pos [3];
   logic signed [15:0] req_nrm [3];
   logic [63:0]        req_bones, req_weights;
   logic [7:0]         load_bone;
   logic [3:0]         load_entry;
   logic [31:0]        load_value;

   assign req_pos[0]  = req_tdata[31:0];
   assign req_pos[1]  = req_tdata[63:32];
   assign req_pos[2]  = req_tdata[95:64];
   assign req_nrm[0]  = req_tdata[111:96];
   assign req_nrm[1]  = req_tdata[127:112];
   assign req_nrm[2]  = req_tdata[143:128];
   assign req_bones   = req_tdata[207:144];
   assign req_weights = req_tdata[271:208];
   assign load_bone   = req_tdata[279:272];
   assign load_entry  = req_tdata[283:280];
   assign load_value  = req_tdata[315:284];

   state_type           st_ff, st_in;
   logic [BCNT_W-1:0]   bcnt_ff;
   logic signed [31:0]  pos_ff [3];
   logic signed [31:0]  pos_in [3];
   logic signed [15:0]  nrm_ff [3];
   logic signed [15:0]  nrm_in [3];
   logic [63:0]         bones_ff, bones_in, wts_ff, wts_in;
   logic [KIDX_W-1:0]   k_ff, k_in;
   logic [BONE_W-1:0]   bone_ff, bone_in;
   logic [15:0]         w_ff, w_in;
   logic [1:0]          r_ff, r_in, c_ff, c_in;
   logic [31:0]         m_ff, m_in;
   logic signed [63:0]  prod_p_ff, prod_p_in;
   logic signed [47:0]  prod_n_ff, prod_n_in;
   logic signed [ROW_W-1:0] prow_ff, prow_in, nrow_ff, nrow_in;
   logic signed [50:0]  wp_hi_ff, wp_hi_in, wn_hi_ff, wn_hi_in;
   logic [31:0]         wp_lo_ff, wp_lo_in, wn_lo_ff, wn_lo_in;
   logic signed [ACC_W-1:0] pacc_ff [3];
   logic signed [ACC_W-1:0] pacc_in [3];
   logic signed [ACC_W-1:0] nacc_ff [3];
   logic signed [ACC_W-1:0] nacc_in [3];
   logic [17:0]         total_ff, total_in;
   logic [RSP_W-1:0]    res_ff, res_in;
   logic                pt_ff, pt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                rsp_user_ff, rsp_user_in;

   logic                req_beat, out_free;
   logic                ram_we, ram_re;
   logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
   logic [31:0]         ram_rdata;
   logic                nrm_start, nrm_done;
   logic signed [15:0]  nrm_ox, nrm_oy, nrm_oz;
   logic [15:0]         cur_w, cur_b;
   logic signed [31:0]  sat [3];

   assign req_tready = (st_ff == S_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // current influence; influences past the packed four weigh nothing
   assign cur_w = (32'(k_ff) < PACKED_INFL) ? 16'(wts_ff >> {k_ff, 4'b0}) : 16'd0;
   assign cur_b = (32'(k_ff) < PACKED_INFL) ? 16'(bones_ff >> {k_ff, 4'b0}) : 16'd0;

   // store write: drop loads aimed at a missing slot or word
   assign ram_we    = req_beat && (op_type'(req_tuser[0]) == OP_LOAD)
                      && (32'(load_entry) < MAT_WORDS) && (32'(load_bone) < MAX_BONES);
   assign ram_waddr = ADDR_W'(32'(load_bone) * MAT_WORDS + 32'(load_entry));
   assign ram_re    = (st_ff == S_RD);
   assign ram_raddr = ADDR_W'(32'(bone_ff) * MAT_WORDS + 32'(r_ff) * MAT_COLS + 32'(c_ff));

   lbvs_ram #(
      .WIDTH (32),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (load_value),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign nrm_start = (st_ff == S_INFL) && (32'(k_ff) == INFLUENCES)
                      && (32'(total_ff) > WEIGHT_EPS);

   lbvs_norm u_norm (
      .clock  (clock),
      .reset  (reset),
      .start  (nrm_start),
      .vec_x  (nacc_ff[0]),
      .vec_y  (nacc_ff[1]),
      .vec_z  (nacc_ff[2]),
      .done   (nrm_done),
      .nrm_x  (nrm_ox),
      .nrm_y  (nrm_oy),
      .nrm_z  (nrm_oz)
   );

   // saturate the position sums to 32 bits
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (pacc_ff[i] > ACC_W'(64'sd2147483647)) begin
            sat[i] = 32'sh7fffffff;
         end else if (pacc_ff[i] < -ACC_W'(64'sd2147483648)) begin
            sat[i] = 32'sh80000000;
         end else begin
            sat[i] = 32'(pacc_ff[i]);
         end
      end
   end

   always_comb begin
      st_in     = st_ff;
      pos_in    = pos_ff;
      nrm_in    = nrm_ff;
      bones_in  = bones_ff;
      wts_in    = wts_ff;
      k_in      = k_ff;
      bone_in   = bone_ff;
      w_in      = w_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      m_in      = m_ff;
      prod_p_in = prod_p_ff;
      prod_n_in = prod_n_ff;
      prow_in   = prow_ff;
      nrow_in   = nrow_ff;
      wp_hi_in  = wp_hi_ff;
      wp_lo_in  = wp_lo_ff;
      wn_hi_in  = wn_hi_ff;
      wn_lo_in  = wn_lo_ff;
      pacc_in   = pacc_ff;
      nacc_in   = nacc_ff;
      total_in  = total_ff;
      res_in    = res_ff;
      pt_in     = pt_ff;
      case (st_ff)
         S_IDLE: begin
            // latch a skin beat and clear the sums
            if (req_beat && (op_type'(req_tuser[0]) == OP_SKIN)) begin
               pos_in   = req_pos;
               nrm_in   = req_nrm;
               bones_in = req_bones;
               wts_in   = req_weights;
               k_in     = '0;
               total_in = '0;
               for (int i = 0; i < 3; i++) begin
                  pacc_in[i] = '0;
                  nacc_in[i] = '0;
               end
               st_in = S_INFL;
            end
         end
         S_INFL: begin
            if (32'(k_ff) == INFLUENCES) begin
               if (32'(total_ff) > WEIGHT_EPS) begin
                  st_in = S_NORM;
               end else begin
                  // too little weight: hand back the rest vertex
                  res_in = {nrm_ff[2], nrm_ff[1], nrm_ff[0], pos_ff[2], pos_ff[1], pos_ff[0]};
                  pt_in  = 1'b1;
                  st_in  = S_OUT;
               end
            end else if ((32'(cur_w) > WEIGHT_EPS) && (32'(cur_b) < 32'(bcnt_ff))
                         && (32'(cur_b) < MAX_BONES)) begin
               bone_in = BONE_W'(cur_b);
               w_in    = cur_w;
               r_in    = '0;
               c_in    = '0;
               prow_in = '0;
               nrow_in = '0;
               st_in   = S_RD;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_RD: begin
            st_in = S_EX;
         end
         S_EX: begin
            m_in      = ram_rdata;
            prod_p_in = $signed(ram_rdata) * pos_ff[c_ff];
            prod_n_in = $signed(ram_rdata) * nrm_ff[c_ff];
            st_in     = S_AC;
         end
         S_AC: begin
            if (c_ff != 2'd3) begin
               prow_in = prow_ff + ROW_W'(prod_p_ff >>> 16);
               nrow_in = nrow_ff + ROW_W'(prod_n_ff);
               c_in    = c_ff + 2'd1;
               st_in   = S_RD;
            end else begin
               // translation column
               prow_in = prow_ff + ROW_W'($signed(m_ff));
               st_in   = S_WT;
            end
         end
         S_WT: begin
            // floor(x * w / 2^16) as high part times w plus the low part's carry
            wp_hi_in = $signed(prow_ff[ROW_W-1:16]) * $signed({1'b0, w_ff});
            wp_lo_in = prow_ff[15:0] * w_ff;
            wn_hi_in = $signed(nrow_ff[ROW_W-1:16]) * $signed({1'b0, w_ff});
            wn_lo_in = nrow_ff[15:0] * w_ff;
            st_in    = S_WA;
         end
         S_WA: begin
            pacc_in[r_ff] = pacc_ff[r_ff] + ACC_W'(wp_hi_ff) + ACC_W'(wp_lo_ff[31:16]);
            nacc_in[r_ff] = nacc_ff[r_ff] + ACC_W'(wn_hi_ff) + ACC_W'(wn_lo_ff[31:16]);
            if (r_ff == 2'd2) begin
               total_in = total_ff + 18'(w_ff);
               k_in     = k_ff + 1'b1;
               st_in    = S_INFL;
            end else begin
               r_in    = r_ff + 2'd1;
               c_in    = '0;
               prow_in = '0;
               nrow_in = '0;
               st_in   = S_RD;
            end
         end
         S_NORM: begin
            if (nrm_done) begin
               res_in = {nrm_oz, nrm_oy, nrm_ox, sat[2], sat[1], sat[0]};
               pt_in  = 1'b0;
               st_in  = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               st_in = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   // output register: hold until taken, refill in the same beat
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if ((st_ff == S_OUT) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
         rsp_user_in  = pt_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         bcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            bcnt_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      nrm_ff      <= nrm_in;
      bones_ff    <= bones_in;
      wts_ff      <= wts_in;
      k_ff        <= k_in;
      bone_ff     <= bone_in;
      w_ff        <= w_in;
      r_ff        <= r_in;
      c_ff        <= c_in;
      m_ff        <= m_in;
      prod_p_ff   <= prod_p_in;
      prod_n_ff   <= prod_n_in;
      prow_ff     <= prow_in;
      nrow_ff     <= nrow_in;
      wp_hi_ff    <= wp_hi_in;
      wp_lo_ff    <= wp_lo_in;
      wn_hi_ff    <= wn_hi_in;
      wn_lo_ff    <= wn_lo_in;
      pacc_ff     <= pacc_in;
      nacc_ff     <= nacc_in;
      total_ff    <= total_in;
      res_ff      <= res_in;
      pt_ff       <= pt_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // store is only written between vertices
   a_we_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (st_ff == S_IDLE))
      else $error("matrix store written mid-vertex");

   // a completed result always lands in the output register
   a_out_load: assert property (@(posedge clock) disable iff (reset)
      ((st_ff == S_OUT) && out_free) |=> (rsp_valid_ff && (rsp_user_ff == $past(pt_ff))))
      else $error("result lost on hand-off");

   // normaliser never reports done straight after a start
   a_norm_lat: assert property (@(posedge clock) disable iff (reset)
      nrm_start |=> !nrm_done)
      else $error("normaliser done too early");

   // influence counter stays within the influence list
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      (st_ff != S_IDLE) |-> (32'(k_ff) <= INFLUENCES))
      else $error("influence index overrun");
endmodule

/* dv/tb_linear_blend_vertex_skinning.sv */
// Self-checking testbench for linear_blend_vertex_skinning: a predictor of the
// skinning arithmetic runs beside the block and each response beat is compared with it.
// Depends on lbvs_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_linear_blend_vertex_skinning;
   import lbvs_pkg::*;

   localparam int TIMEOUT_CYCLES = 3_000_000;

   // Fields of one response beat, in the order they sit in {rsp_tuser, rsp_tdata}
   typedef struct packed {
      logic        thru;
      logic [15:0] nz;
      logic [15:0] ny;
      logic [15:0] nx;
      logic [31:0] pz;
      logic [31:0] py;
      logic [31:0] px;
   } vertex_out_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata = '0;
   logic [0:0]         req_tuser = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic [0:0]         rsp_tuser;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [BCNT_W-1:0]  csr_wdata = '0;

   // Predictor state: a shadow of the matrix store and of bone_count
   logic [31:0]        shadow_mat [MAX_BONES*MAT_WORDS];
   bit                 shadow_written [MAX_BONES];
   int unsigned        shadow_bones;

   vertex_out_type     skinned_q[$];
   int unsigned        send_idle_pct;
   int unsigned        recv_stall_pct;
   int unsigned        mismatches;
   longint unsigned    cycle_count;

   linear_blend_vertex_skinning u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // ---------------------------------------------------------------- arithmetic
   function automatic longint floor_div16(longint x);
      return x >>> 16;
   endfunction

   // floor(x * w / 2^16), exact for the widths in play
   function automatic longint weigh(longint x, longint w);
      longint hi;
      longint lo;
      hi = x >>> 16;
      lo = x - hi * 65536;
      return hi * w + ((lo * w) >>> 16);
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r;
      longint unsigned bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v -= r + bitv;
            r = (r >> 1) + bitv;
         end else begin
            r >>= 1;
         end
         bitv >>= 2;
      end
      return r;
   endfunction

   function automatic longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Scale so the largest magnitude lies in [2^29, 2^30), then divide by length
   function automatic void unit_normal(input longint c[3], output logic [15:0] o[3]);
      longint unsigned a[3];
      longint unsigned mx;
      longint unsigned sum;
      longint unsigned len;
      longint unsigned q;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = c[i] < 0 ? longint'(-c[i]) : longint'(c[i]);
         if (a[i] > mx) mx = a[i];
      end
      if (mx == 0) begin
         for (int i = 0; i < 3; i++) o[i] = '0;
         return;
      end
      while (mx >= (64'd1 << 30)) begin
         mx >>= 1;
         for (int i = 0; i < 3; i++) a[i] >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
         mx <<= 1;
         for (int i = 0; i < 3; i++) a[i] <<= 1;
      end
      sum = 0;
      for (int i = 0; i < 3; i++) sum += a[i] * a[i];
      len = floor_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = (a[i] * NRM_ONE + len / 2) / len;
         if (q > NRM_ONE) q = NRM_ONE;
         o[i] = c[i] < 0 ? 16'(-longint'(q)) : 16'(q);
      end
   endfunction

   // Work out the response of one skin beat from the shadow store
   function automatic vertex_out_type skin_vertex(logic [REQ_W-1:0] d);
      vertex_out_type  r;
      longint          pos[3];
      longint          nrm[3];
      longint          pacc[3];
      longint          nacc[3];
      logic [15:0]     un[3];
      longint          m0, m1, m2, t, p, n, w;
      int unsigned     b;
      int unsigned     bc;
      int unsigned     total;
      bc = shadow_bones > MAX_BONES ? MAX_BONES : shadow_bones;
      total = 0;
      for (int i = 0; i < 3; i++) begin
         pos[i] = longint'($signed(d[32*i +: 32]));
         nrm[i] = longint'($signed(d[96 + 16*i +: 16]));
         pacc[i] = 0;
         nacc[i] = 0;
      end
      for (int k = 0; k < 4; k++) begin
         b = 32'(d[144 + 16*k +: 16]);
         w = longint'(d[208 + 16*k +: 16]);
         if (w <= WEIGHT_EPS || b >= bc) continue;
         for (int rr = 0; rr < 3; rr++) begin
            m0 = longint'($signed(shadow_mat[b*MAT_WORDS + rr*4]));
            m1 = longint'($signed(shadow_mat[b*MAT_WORDS + rr*4 + 1]));
            m2 = longint'($signed(shadow_mat[b*MAT_WORDS + rr*4 + 2]));
            t  = longint'($signed(shadow_mat[b*MAT_WORDS + rr*4 + 3]));
            p = floor_div16(m0*pos[0]) + floor_div16(m1*pos[1])
              + floor_div16(m2*pos[2]) + t;
            n = m0*nrm[0] + m1*nrm[1] + m2*nrm[2];
            pacc[rr] += weigh(p, w);
            nacc[rr] += weigh(n, w);
         end
         total += int'(w);
      end
      if (total > WEIGHT_EPS) begin
         unit_normal(nacc, un);
         r.px = 32'(sat32(pacc[0]));
         r.py = 32'(sat32(pacc[1]));
         r.pz = 32'(sat32(pacc[2]));
         r.nx = un[0];
         r.ny = un[1];
         r.nz = un[2];
         r.thru = 1'b0;
      end else begin
         r.px = d[31:0];
         r.py = d[63:32];
         r.pz = d[95:64];
         r.nx = d[111:96];
         r.ny = d[127:112];
         r.nz = d[143:128];
         r.thru = 1'b1;
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers
   // Send one beat; predict on acceptance. Valid stays up on return so the
   // next beat can follow at once; idle gaps and drains drop it.
   task automatic send_beat(op_type op, logic [REQ_W-1:0] d);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (op == OP_LOAD) begin
         if (d[283:280] < MAT_WORDS) begin
            shadow_mat[32'(d[279:272])*MAT_WORDS + 32'(d[283:280])] = d[315:284];
            if (d[283:280] == MAT_WORDS - 1) shadow_written[d[279:272]] = 1'b1;
         end
      end else begin
         skinned_q.push_back(skin_vertex(d));
      end
      @(negedge clock);
   endtask

   task automatic load_word(int unsigned bone, int unsigned entry, logic [31:0] v);
      logic [REQ_W-1:0] d;
      d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom};
      d[279:272] = 8'(bone);
      d[283:280] = 4'(entry);
      d[315:284] = v;
      d[319:316] = '0;
      send_beat(OP_LOAD, d);
   endtask

   // Random matrix, linear entries within +-1.0 or wild, to exercise saturation too
   task automatic load_bone_matrix(int unsigned bone, bit wild);
      logic [31:0] v;
      for (int e = 0; e < MAT_WORDS; e++) begin
         if (wild) v = $urandom;
         else if (e % 4 == 3) v = 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
         else v = 32'($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
         load_word(bone, e, v);
      end
   endtask

   function automatic logic [15:0] rand_nrm();
      return 16'($signed($urandom_range(0, 32768)) - 16384);
   endfunction

   // Skin beat: bones mostly from loaded slots, else out of range; weights up to 8, up to 0x4000 or full range
   task automatic skin_random(int unsigned hi_bone);
      logic [REQ_W-1:0] d;
      int unsigned      b;
      d = '0;
      for (int i = 0; i < 3; i++) d[32*i +: 32] = $urandom;
      if ($urandom_range(3) == 0)
         for (int i = 0; i < 3; i++) d[32*i +: 32] = $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
      for (int i = 0; i < 3; i++) d[96 + 16*i +: 16] = rand_nrm();
      if ($urandom_range(15) == 0) d[143:96] = 48'({$urandom, $urandom});
      for (int k = 0; k < 4; k++) begin
         do begin
            b = ($urandom_range(7) == 0) ? $urandom_range(0, 16'hFFFF) : $urandom_range(0, hi_bone);
         end while (b < MAX_BONES && !shadow_written[b]);
         d[144 + 16*k +: 16] = 16'(b);
         case ($urandom_range(3))
            0: d[208 + 16*k +: 16] = 16'($urandom_range(0, 8));
            1: d[208 + 16*k +: 16] = 16'($urandom_range(0, 16'hFFFF));
            default: d[208 + 16*k +: 16] = 16'($urandom_range(0, 16'h4000));
         endcase
      end
      send_beat(OP_SKIN, d);
   endtask

   task automatic write_bone_count(int unsigned v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= BCNT_W'(v);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shadow_bones = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Drain all expected beats, then let a trailing load settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (skinned_q.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_idling(int unsigned s, int unsigned r);
      send_idle_pct = s;
      recv_stall_pct = r;
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_directed();
      logic [REQ_W-1:0] d;
      write_bone_count(4);
      load_bone_matrix(0, 0);
      load_bone_matrix(1, 1);
      for (int e = 0; e < MAT_WORDS; e++) begin
         load_word(2, e, 32'h8000_0000);
         load_word(3, e, (e % 5 == 0) ? 32'h0001_0000 : 32'h0);
      end
      // Bad load slot: entry above eleven is dropped
      load_word(0, 15, 32'hDEAD_BEEF);
      load_word(255, 12, 32'h1234_5678);
      // Identity bone, full weight
      d = '0;
      d[31:0] = 32'h7FFF_FFFF; d[63:32] = 32'h8000_0000; d[95:64] = 32'h0001_0000;
      d[111:96] = 16'd16384; d[127:112] = 16'hC000; d[143:128] = 16'd0;
      d[144 +: 16] = 16'd3; d[208 +: 16] = 16'hFFFF;
      send_beat(OP_SKIN, d);
      // Weights all at threshold: pass through
      d[208 +: 64] = {16'd6, 16'd6, 16'd6, 16'd6};
      send_beat(OP_SKIN, d);
      // Bone out of range
      d[144 +: 64] = {16'hFFFF, 16'd200, 16'd4, 16'd5};
      d[208 +: 64] = {4{16'hFFFF}};
      send_beat(OP_SKIN, d);
      // Saturating bone, all four influences
      d[144 +: 64] = {16'd2, 16'd2, 16'd1, 16'd0};
      send_beat(OP_SKIN, d);
      // Zero normal
      d[111:96] = '0; d[127:112] = '0; d[143:128] = '0;
      d[144 +: 16] = 16'd3; d[208 +: 64] = {48'd0, 16'd7};
      send_beat(OP_SKIN, d);
      d[31:0] = 32'h8000_0000; d[63:32] = 32'h7FFF_FFFF; d[95:64] = 32'hFFFF_FFFF;
      d[111:96] = 16'hFFFF; d[127:112] = 16'h8000; d[143:128] = 16'h7FFF;
      d[208 +: 64] = {4{16'h8000}}; d[144 +: 64] = {16'd3, 16'd2, 16'd1, 16'd0};
      send_beat(OP_SKIN, d);
      drain();
      // Zero bones: everything passes through
      write_bone_count(0);
      send_beat(OP_SKIN, d);
      drain();
   endtask

   task automatic test_full_store();
      write_bone_count(256);
      // load a spread of slots across the whole store, top slot included
      for (int b = 0; b < MAX_BONES; b++)
         if ((b % 16 == 0 || b == MAX_BONES - 1) && (!shadow_written[b] || $urandom_range(3) == 0))
            load_bone_matrix(b, $urandom_range(4) == 0);
      for (int i = 0; i < 60; i++) skin_random(255);
      drain();
      write_bone_count(511);
      for (int i = 0; i < 60; i++) skin_random(255);
      drain();
   endtask

   task automatic test_random_phase(int unsigned s, int unsigned r, int unsigned n);
      set_idling(s, r);
      write_bone_count($urandom_range(1, 300));
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0)
            load_word($urandom_range(255), $urandom_range(15), $urandom);
         else if ($urandom_range(59) == 0)
            load_bone_matrix($urandom_range(255), $urandom_range(1));
         else
            skin_random(255);
         // Hold off once, halfway through, until the pipeline is empty
         if (i == n / 2) begin
            req_tvalid <= 1'b0;
            while (skinned_q.size() != 0) @(posedge clock);
            @(negedge clock);
         end
      end
      drain();
   endtask

   // ---------------------------------------------------------------- checker
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      vertex_out_type got;
      vertex_out_type want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tuser, rsp_tdata};
         if (skinned_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response beat %h", got);
         end else begin
            want = skinned_q.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: expected pos %h %h %h nrm %h %h %h thru %b,",
                            " got pos %h %h %h nrm %h %h %h thru %b"},
                           want.px, want.py, want.pz, want.nx, want.ny, want.nz, want.thru,
                           got.px, got.py, got.pz, got.nx, got.ny, got.nz, got.thru);
            end
         end
      end
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("tb_linear_blend_vertex_skinning failed");
         $finish;
      end
   end

   initial begin
      mismatches = 0;
      cycle_count = 0;
      shadow_bones = 0;
      set_idling(0, 0);
      for (int b = 0; b < MAX_BONES; b++) shadow_written[b] = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_full_store();
      test_random_phase(0, 0, 280);
      test_random_phase(46, 0, 280);
      test_random_phase(0, 46, 280);
      test_random_phase(29, 29, 280);
      if (skinned_q.size() == 0 && mismatches == 0)
         $display("tb_linear_blend_vertex_skinning passed");
      else
         $display("tb_linear_blend_vertex_skinning failed");
      $finish;
   end
endmodule

/* filelist.f */
rtl/core/lbvs_pkg.sv
rtl/core/lbvs_ram.sv
rtl/core/lbvs_norm.sv
rtl/core/linear_blend_vertex_skinning.sv
dv/tb_linear_blend_vertex_skinning.sv
